[hdl/pps_pkg.sv]
// Shared constants and the candidate record for the priority scheduler.
package pps_pkg;

	localparam int SlotW    = 3;
	localparam int IdW      = 8;
	localparam int TimeW    = 16;
	localparam int PrioW    = 4;
	localparam int SlotsDef = 8;

	localparam logic FuncLoad = 1'b0;
	localparam logic FuncTick = 1'b1;

	// Record that travels down the chain of cells during one scheduling scan.
	typedef struct packed {
		logic             tok;       // Scan token is in this stage.
		logic             have;      // A best eligible task has been found.
		logic [PrioW-1:0] prio;      // Priority of the best task so far.
		logic [TimeW-1:0] arrival;   // Arrival tick of the best task so far.
		logic [IdW-1:0]   id;        // Id of the best task so far.
		logic             last;      // Best task has one unit of work left.
		logic             run_ok;    // The running task is still eligible.
		logic [PrioW-1:0] run_prio;
		logic [IdW-1:0]   run_id;
		logic             run_last;
	} cand_t;

	// Commands broadcast from the top level to every cell.
	typedef struct packed {
		logic             load_en;
		logic [SlotW-1:0] load_slot;
		logic [IdW-1:0]   id;
		logic [TimeW-1:0] arrival;
		logic [TimeW-1:0] burst;
		logic [PrioW-1:0] prio;
		logic             dec_en;
		logic             run_valid;
		logic [TimeW-1:0] now;
	} cell_cmd_t;

endpackage

[hdl/preemptive_priority_scheduler_unit.sv]
// Top level of the preemptive priority scheduler: command port, cell chain and tick finish.
//
// Usage: an item is transferred at a rising edge where start is high and busy is low.
// With func = load the item writes one task slot (id, arrival, burst, priority) in that
// same edge with no result; busy stays low, so a load can follow every cycle when idle.
// With func = tick a scan token enters the first cell and moves one cell per cycle down a
// chain of SLOTS cells, each of which holds one slot and folds its entry into the best
// candidate so far. The chain also picks up the state of the currently running task.
// When the token leaves the last cell, the finish step chooses between the running task
// and the best waiting one, retires one unit of work and registers the result.
// The result of a tick is registered after the finish step and shown with result_valid
// high for exactly one cycle; busy drops in that same cycle so the next item may be
// transferred while the result is on the ports. A new tick is taken only after the
// last one has reported, so the length of the cell chain sets the tick rate.
// The receiver cannot stall, so a result is never held back.
// Reset clears the remaining work of every slot, the running mark, the time counter and
// the control flops; task id, arrival and priority hold garbage until a load writes them.
// Loads to a slot number at or above SLOTS are ignored. The time counter stops at its
// maximum and repeats that value on later ticks.
module preemptive_priority_scheduler_unit
	import pps_pkg::*;
#(
	parameter int SLOTS = SlotsDef,
	localparam int IW   = $clog2(SLOTS),
	localparam int CW   = (IW > SlotW) ? IW : SlotW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             func,
	input  logic [SlotW-1:0] slot,
	input  logic [IdW-1:0]   task_id,
	input  logic [TimeW-1:0] arrival,
	input  logic [TimeW-1:0] burst,
	input  logic [PrioW-1:0] prio,
	output logic             result_valid,
	output logic [IdW-1:0]   running_id,
	output logic             finished,
	output logic [TimeW-1:0] tick_time
);

	logic             accept;
	logic             busy_q;
	logic             run_valid_q;
	logic [IW-1:0]    run_slot_q;
	logic [TimeW-1:0] now_q;
	logic             valid_q;
	logic [IdW-1:0]   id_q;
	logic             fin_q;
	logic [TimeW-1:0] time_q;

	cell_cmd_t        cmd;
	cand_t            seed;
	cand_t            cand [0:SLOTS];
	logic [IW-1:0]    idx  [0:SLOTS];

	// Finish step signals.
	cand_t            fin_cand;
	logic             finish;
	logic             run_any;
	logic             take_best;
	logic [IW-1:0]    chosen;
	logic [IdW-1:0]   chosen_id;
	logic             chosen_last;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// The seed enters the first cell combinationally at the tick transfer edge.
	always_comb begin
		seed     = '0;
		seed.tok = accept && (func == FuncTick);
	end

	assign cand[0] = seed;
	assign idx[0]  = '0;

	always_comb begin
		cmd.load_en   = accept && (func == FuncLoad);
		cmd.load_slot = slot;
		cmd.id        = task_id;
		cmd.arrival   = arrival;
		cmd.burst     = burst;
		cmd.prio      = prio;
		cmd.dec_en    = finish && run_any;
		cmd.run_valid = run_valid_q;
		cmd.now       = now_q;
	end

	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_cell
			pps_cell #(
				.SLOTS (SLOTS),
				.IDX   (g)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.dec_idx  (chosen),
				.run_slot (run_slot_q),
				.cand_in  (cand[g]),
				.idx_in   (idx[g]),
				.cand_out (cand[g+1]),
				.idx_out  (idx[g+1])
			);
		end
	endgenerate

	// The running task keeps the processor unless the best waiting one has a strictly
	// higher priority; with no eligible running task the best waiting one runs.
	always_comb begin
		fin_cand  = cand[SLOTS];
		finish    = fin_cand.tok;
		run_any   = fin_cand.run_ok || fin_cand.have;
		take_best = !fin_cand.run_ok ||
			(fin_cand.have && (fin_cand.prio > fin_cand.run_prio));
		if (take_best) begin
			chosen      = idx[SLOTS];
			chosen_id   = fin_cand.id;
			chosen_last = fin_cand.last;
		end else begin
			chosen      = run_slot_q;
			chosen_id   = fin_cand.run_id;
			chosen_last = fin_cand.run_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			run_valid_q <= 1'b0;
			run_slot_q  <= '0;
			now_q       <= '0;
			valid_q     <= 1'b0;
		end else begin
			valid_q <= finish;
			if (accept && (func == FuncTick)) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (cmd.load_en && run_valid_q && (CW'(run_slot_q) == CW'(slot))) begin
				// Overwriting the running slot drops the running mark.
				run_valid_q <= 1'b0;
			end else if (finish) begin
				if (run_any && !chosen_last) begin
					run_valid_q <= 1'b1;
					run_slot_q  <= chosen;
				end else begin
					run_valid_q <= 1'b0;
				end
			end
			if (finish && (now_q != '1)) begin
				now_q <= now_q + TimeW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			id_q   <= run_any ? chosen_id : '0;
			fin_q  <= run_any && chosen_last;
			time_q <= now_q;
		end
	end

	assign result_valid = valid_q;
	assign running_id   = id_q;
	assign finished     = fin_q;
	assign tick_time    = time_q;

endmodule

[hdl/pps_cell.sv]
// One task slot of the scheduler, comparing its entry against the passing candidate.
module pps_cell
	import pps_pkg::*;
#(
	parameter int SLOTS = SlotsDef,
	parameter int IDX   = 0,
	localparam int IW   = $clog2(SLOTS),
	localparam int CW   = (IW > SlotW) ? IW : SlotW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_cmd_t     cmd,
	input  logic [IW-1:0] dec_idx,
	input  logic [IW-1:0] run_slot,
	input  cand_t         cand_in,
	input  logic [IW-1:0] idx_in,
	output cand_t         cand_out,
	output logic [IW-1:0] idx_out
);

	logic [IdW-1:0]   id_q;
	logic [TimeW-1:0] arrival_q;
	logic [TimeW-1:0] remaining_q;
	logic [PrioW-1:0] prio_q;
	logic             eligible;
	logic             wins;
	logic             is_run;
	cand_t            cand_nxt;
	logic [IW-1:0]    idx_nxt;

	assign eligible = (remaining_q != '0) && (arrival_q <= cmd.now);
	// Earlier cells hold lower slots, so a full tie keeps the incoming candidate.
	assign wins = eligible && (!cand_in.have || (prio_q > cand_in.prio) ||
		((prio_q == cand_in.prio) && (arrival_q < cand_in.arrival)));
	assign is_run = cmd.run_valid && (run_slot == IW'(IDX));

	always_comb begin
		cand_nxt = cand_in;
		idx_nxt  = idx_in;
		if (wins) begin
			cand_nxt.have    = 1'b1;
			cand_nxt.prio    = prio_q;
			cand_nxt.arrival = arrival_q;
			cand_nxt.id      = id_q;
			cand_nxt.last    = (remaining_q == TimeW'(1));
			idx_nxt          = IW'(IDX);
		end
		if (is_run) begin
			cand_nxt.run_ok   = eligible;
			cand_nxt.run_prio = prio_q;
			cand_nxt.run_id   = id_q;
			cand_nxt.run_last = (remaining_q == TimeW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			cand_out    <= '0;
			idx_out     <= '0;
		end else begin
			cand_out <= cand_nxt;
			idx_out  <= idx_nxt;
			if (cmd.load_en && (CW'(cmd.load_slot) == CW'(IDX))) begin
				remaining_q <= cmd.burst;
			end else if (cmd.dec_en && (dec_idx == IW'(IDX))) begin
				remaining_q <= remaining_q - TimeW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_en && (CW'(cmd.load_slot) == CW'(IDX))) begin
			id_q      <= cmd.id;
			arrival_q <= cmd.arrival;
			prio_q    <= cmd.prio;
		end
	end

endmodule

[hdl/pps_checker.sv]
// Port-level checks on the scheduler's command and result timing, bound to the top level.
module pps_port_checker
	import pps_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic func,
	input logic result_valid
);

	// A result pulse lasts exactly one cycle.
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for more than one cycle");

	// A tick transfer makes the block busy until its result.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == FuncTick)) |=> busy)
		else $error("tick transfer did not raise busy");

	// A load completes in the cycle of its transfer.
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == FuncLoad)) |=> !busy)
		else $error("load transfer raised busy");

	// Busy ends only together with a result.
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid)
		else $error("busy dropped without a result");

	// A result never appears while a scan is still running.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result shown while busy");

endmodule

bind preemptive_priority_scheduler_unit pps_port_checker u_pps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.func         (func),
	.result_valid (result_valid)
);

[tb/sv/pps_checker.sv]
// Checker for the priority scheduler: follows both channels, predicts every tick and compares.
`timescale 1ns / 100ps
module pps_checker
	import pps_pkg::*;
#(
	parameter int SLOTS = SlotsDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic             func,
	input  logic [SlotW-1:0] slot,
	input  logic [IdW-1:0]   task_id,
	input  logic [TimeW-1:0] arrival,
	input  logic [TimeW-1:0] burst,
	input  logic [PrioW-1:0] prio,
	input  logic             result_valid,
	input  logic [IdW-1:0]   running_id,
	input  logic             finished,
	input  logic [TimeW-1:0] tick_time,
	output int               errors,
	output int               pending
);

	typedef struct packed {
		logic [IdW-1:0]   id;
		logic             fin;
		logic [TimeW-1:0] when;
	} tick_report_t;

	logic [IdW-1:0]   task_tab_id   [SLOTS];
	logic [TimeW-1:0] task_tab_arr  [SLOTS];
	logic [TimeW-1:0] task_tab_left [SLOTS];
	logic [PrioW-1:0] task_tab_prio [SLOTS];
	int               cur_slot;
	logic             cur_valid;
	logic [TimeW-1:0] sched_now;
	tick_report_t     due_reports [$];
	int               err_cnt;

	// Higher priority wins, then the earlier arrival, then the lower slot.
	function automatic bit outranks(int a, int b);
		if (task_tab_prio[a] != task_tab_prio[b])
			return task_tab_prio[a] > task_tab_prio[b];
		if (task_tab_arr[a] != task_tab_arr[b])
			return task_tab_arr[a] < task_tab_arr[b];
		return a < b;
	endfunction

	task automatic store_task();
		if (int'(slot) < SLOTS) begin
			task_tab_id[slot]   = task_id;
			task_tab_arr[slot]  = arrival;
			task_tab_left[slot] = burst;
			task_tab_prio[slot] = prio;
			if (cur_valid && cur_slot == int'(slot))
				cur_valid = 1'b0;
		end
	endtask

	task automatic schedule_tick(output tick_report_t rep);
		int best;
		int pick;
		bit have;
		bit run;
		best = 0;
		pick = 0;
		have = 1'b0;
		run  = 1'b0;
		rep  = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (task_tab_left[i] != '0 && task_tab_arr[i] <= sched_now
					&& (!have || outranks(i, best))) begin
				best = i;
				have = 1'b1;
			end
		end
		if (cur_valid && cur_slot < SLOTS && task_tab_left[cur_slot] != '0
				&& task_tab_arr[cur_slot] <= sched_now) begin
			pick = cur_slot;
			run  = 1'b1;
			if (have && task_tab_prio[best] > task_tab_prio[cur_slot])
				pick = best;
		end else if (have) begin
			pick = best;
			run  = 1'b1;
		end
		if (run) begin
			rep.id = task_tab_id[pick];
			task_tab_left[pick] = task_tab_left[pick] - TimeW'(1);
			if (task_tab_left[pick] == '0) begin
				rep.fin   = 1'b1;
				cur_valid = 1'b0;
			end else begin
				cur_valid = 1'b1;
				cur_slot  = pick;
			end
		end else begin
			cur_valid = 1'b0;
		end
		rep.when = sched_now;
		if (sched_now != '1)
			sched_now = sched_now + TimeW'(1);
	endtask

	task automatic flag(string what, logic [TimeW-1:0] want, logic [TimeW-1:0] got);
		err_cnt++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		tick_report_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				task_tab_id[i]   = '0;
				task_tab_arr[i]  = '0;
				task_tab_left[i] = '0;
				task_tab_prio[i] = '0;
			end
			cur_slot  = 0;
			cur_valid = 1'b0;
			sched_now = '0;
			due_reports.delete();
			err_cnt = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			// A result belongs to an earlier tick, so it is checked before this edge's transfer.
			if (result_valid) begin
				if (due_reports.size() == 0) begin
					err_cnt++;
					$display("%0t: result with none expected, id %0d time %0d",
						$time, running_id, tick_time);
				end else begin
					want = due_reports.pop_front();
					if (running_id !== want.id)
						flag("running_id", TimeW'(want.id), TimeW'(running_id));
					if (finished !== want.fin)
						flag("finished", TimeW'(want.fin), TimeW'(finished));
					if (tick_time !== want.when)
						flag("tick_time", want.when, tick_time);
				end
			end
			if (start && !busy) begin
				if (func == FuncTick) begin
					schedule_tick(want);
					due_reports.push_back(want);
				end else begin
					store_task();
				end
			end
			errors  <= err_cnt;
			pending <= due_reports.size();
		end
	end

endmodule

[tb/sv/tb.sv]
// Testbench top for the priority scheduler: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps
module tb;
	import pps_pkg::*;

	localparam int SLOTS      = SlotsDef;
	// A tick passes through every cell of the chain and then the finish step.
	localparam int TickLat    = SLOTS + 1;
	// A full run stays well under CycleLimit, even with every gap at its longest.
	localparam int CycleLimit = 200_000;
	localparam int PhaseItems = 225;

	logic             clk     = 1'b0;
	logic             arst_n  = 1'b0;
	logic             start   = 1'b0;
	logic             func    = FuncLoad;
	logic [SlotW-1:0] slot    = '0;
	logic [IdW-1:0]   task_id = '0;
	logic [TimeW-1:0] arrival = '0;
	logic [TimeW-1:0] burst   = '0;
	logic [PrioW-1:0] prio    = '0;
	logic             busy;
	logic             result_valid;
	logic [IdW-1:0]   running_id;
	logic             finished;
	logic [TimeW-1:0] tick_time;
	int               errors;
	int               pending;

	// Counts kept by the stimulus side; sched_time mirrors the block's clock so that
	// arrivals can be placed close to the present and tasks actually get to run.
	int               n_loads = 0;
	int               n_ticks = 0;
	logic [TimeW-1:0] sched_time = '0;
	int               idle_pct [4] = '{0, 57, 0, 28};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	preemptive_priority_scheduler_unit #(
		.SLOTS(SLOTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.slot        (slot),
		.task_id     (task_id),
		.arrival     (arrival),
		.burst       (burst),
		.prio        (prio),
		.result_valid(result_valid),
		.running_id  (running_id),
		.finished    (finished),
		.tick_time   (tick_time)
	);

	pps_checker #(
		.SLOTS(SLOTS)
	) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.slot        (slot),
		.task_id     (task_id),
		.arrival     (arrival),
		.burst       (burst),
		.prio        (prio),
		.result_valid(result_valid),
		.running_id  (running_id),
		.finished    (finished),
		.tick_time   (tick_time),
		.errors      (errors),
		.pending     (pending)
	);

	// Present one item and hold it until the edge where busy is low completes the transfer.
	// start stays high afterwards; the caller lowers it only when a gap follows.
	task automatic transfer(input logic f, input logic [SlotW-1:0] s, input logic [IdW-1:0] id,
			input logic [TimeW-1:0] arr, input logic [TimeW-1:0] b, input logic [PrioW-1:0] p);
		start   <= 1'b1;
		func    <= f;
		slot    <= s;
		task_id <= id;
		arrival <= arr;
		burst   <= b;
		prio    <= p;
		do @(posedge clk); while (busy);
		if (f == FuncTick) begin
			n_ticks++;
			if (sched_time != '1)
				sched_time = sched_time + TimeW'(1);
		end else begin
			n_loads++;
		end
	endtask

	task automatic load_task(input logic [SlotW-1:0] s, input logic [IdW-1:0] id,
			input logic [TimeW-1:0] arr, input logic [TimeW-1:0] b, input logic [PrioW-1:0] p);
		transfer(FuncLoad, s, id, arr, b, p);
	endtask

	// The task fields of a tick are don't-care, so they carry random junk.
	task automatic tick();
		transfer(FuncTick, SlotW'($urandom), IdW'($urandom), TimeW'($urandom),
			TimeW'($urandom), PrioW'($urandom));
	endtask

	// Hold the sender off until every tick in flight has reported.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic maybe_gap(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Mostly arrivals a few ticks around the present, so that tasks compete and ties on
	// arrival are common; now and then anywhere in the 16-bit range.
	function automatic logic [TimeW-1:0] pick_arrival();
		int t;
		if ($urandom_range(0, 9) == 0)
			return TimeW'($urandom_range(0, 65535));
		t = int'(sched_time) + int'($urandom_range(0, 8)) - 3;
		if (t < 0)
			t = 0;
		if (t > 65535)
			t = 65535;
		return TimeW'(t);
	endfunction

	// Short bursts keep slots turning over; zero bursts and full-range bursts are rarer.
	// Priorities lean to a small set so that equal priorities meet often.
	task automatic random_load();
		logic [IdW-1:0]   id;
		logic [TimeW-1:0] b;
		logic [PrioW-1:0] p;
		int               r;
		id = ($urandom_range(0, 99) < 3) ? '0 : IdW'($urandom_range(1, 255));
		r  = int'($urandom_range(0, 99));
		if (r < 5)
			b = '0;
		else if (r < 8)
			b = TimeW'($urandom_range(0, 65535));
		else
			b = TimeW'($urandom_range(1, 6));
		p = $urandom_range(0, 1) ? PrioW'($urandom_range(0, 3)) : PrioW'($urandom_range(0, 15));
		load_task(SlotW'($urandom_range(0, SLOTS - 1)), id, pick_arrival(), b, p);
	endtask

	initial begin : stim
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// An empty table idles at time zero.
		tick();
		// A task with every field at its top value, arriving only at the last tick.
		load_task(3'd0, 8'd255, 16'hFFFF, 16'hFFFF, 4'd15);
		// Nothing has arrived yet, so this tick must idle rather than run slot 0.
		tick();
		// A task with id zero runs and finishes; its id reads like an idle tick, but finished is high.
		load_task(3'd1, 8'd0, 16'd0, 16'd1, 4'd0);
		tick();
		// Three equal priorities: slots 2 and 4 also tie on arrival, so slot 2 wins.
		load_task(3'd2, 8'd10, 16'd0, 16'd3, 4'd5);
		load_task(3'd3, 8'd11, 16'd2, 16'd2, 4'd5);
		load_task(3'd4, 8'd12, 16'd0, 16'd2, 4'd5);
		tick();
		// A strictly higher priority arrival takes the processor.
		load_task(3'd5, 8'd20, 16'd3, 16'd2, 4'd9);
		tick();
		// An equal priority with an earlier arrival does not displace the running task.
		load_task(3'd6, 8'd21, 16'd0, 16'd1, 4'd9);
		tick();
		tick();
		tick();
		// Overwrite the running slot with a zero burst: it drops out and the mark clears.
		load_task(3'd2, 8'd30, 16'd1, 16'd0, 4'd1);
		tick();
		load_task(3'd7, 8'hAA, 16'h5555, 16'hAAAA, 4'd10);
		tick();
		tick();
		drain();

		// Four random phases, some with sender gaps and some without; each ends with a full drain.
		foreach (idle_pct[ph]) begin
			repeat (PhaseItems) begin
				if ($urandom_range(0, 99) < 45)
					random_load();
				else
					tick();
				maybe_gap(idle_pct[ph]);
			end
			drain();
		end

		start <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (3 * TickLat) @(posedge clk);

		$display("Covered %0d task loads and %0d ticks: directed corner cases, then four",
			n_loads, n_ticks);
		$display("random phases with and without sender gaps (last time %0d).", sched_time);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : watchdog
		repeat (CycleLimit) @(posedge clk);
		$display("Timed out after %0d cycles with %0d ticks still unreported.",
			CycleLimit, pending);
		$display("Regression FAIL");
		$finish;
	end

endmodule

[files.f]
hdl/pps_pkg.sv
hdl/pps_cell.sv
hdl/preemptive_priority_scheduler_unit.sv
hdl/pps_checker.sv
tb/sv/pps_checker.sv
tb/sv/tb.sv
